### rtl/ashk_pkg.sv
`timescale 1ns / 1ps

package ashk_pkg;

    // Block constants
    localparam int SAMPLES_PER_PASS  = 50;
    localparam int PASSES_PER_WINDOW = 3;
    localparam int JUMP_COUNT_LIMIT  = 10;
    localparam int FIRST_CHECK_POS   = 2;

    localparam int NUM_AXES    = 3;
    localparam int RAW_W       = 16;
    localparam int GAIN_W      = 16;
    localparam int BIAS_W      = 16;
    localparam int LIM_W       = 20;
    localparam int PROD_W      = 32;
    localparam int SCALE_SHIFT = 12;
    localparam int QUOT_W      = 20;
    localparam int SCALED_W    = 21;
    localparam int MAG_W       = 20;
    localparam int CNT_W       = 8;

    localparam int POS_W  = (SAMPLES_PER_PASS > 2) ? $clog2(SAMPLES_PER_PASS) : 1;
    localparam int PASS_W = (PASSES_PER_WINDOW > 1) ? $clog2(PASSES_PER_WINDOW) : 1;

    localparam logic [POS_W-1:0]  POS_LAST   = POS_W'(SAMPLES_PER_PASS - 1);
    localparam logic [POS_W-1:0]  POS_CHECK  = POS_W'(FIRST_CHECK_POS);
    localparam logic [PASS_W-1:0] PASS_LAST  = PASS_W'(PASSES_PER_WINDOW - 1);
    localparam logic [CNT_W-1:0]  JUMP_LIMIT = CNT_W'(JUMP_COUNT_LIMIT);

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 88;

    localparam int AXIS_Z = 2;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_X   = 3'd0,
        CFG_GAIN_Y   = 3'd1,
        CFG_GAIN_Z   = 3'd2,
        CFG_BIAS_X   = 3'd3,
        CFG_BIAS_Y   = 3'd4,
        CFG_BIAS_Z   = 3'd5,
        CFG_LIMIT_XY = 3'd6,
        CFG_LIMIT_Z  = 3'd7
    } t_cfg_idx;

    localparam logic [GAIN_W-1:0] GAIN_RESET     = GAIN_W'(246);
    localparam logic [BIAS_W-1:0] BIAS_RESET     = '0;
    localparam logic [LIM_W-1:0]  LIMIT_XY_RESET = LIM_W'(40);
    localparam logic [LIM_W-1:0]  LIMIT_Z_RESET  = LIM_W'(50);

    // Window sequencer flags for the sample entering the last stage
    typedef struct packed {
        logic check;
        logic close;
    } t_seq_ctl;

    // Per-lane pipeline controls
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
        logic check;
        logic close;
    } t_lane_ctl;

endpackage

### rtl/ashk_lane.sv
`timescale 1ns / 1ps

module ashk_lane
    import ashk_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_lane_ctl                  i_ctl,
    input  logic signed [RAW_W-1:0]    i_raw,
    input  logic        [GAIN_W-1:0]   i_gain,
    input  logic signed [BIAS_W-1:0]   i_bias,
    input  logic        [LIM_W-1:0]    i_limit,
    output logic signed [SCALED_W-1:0] o_scaled,
    output logic        [CNT_W-1:0]    o_shakes
);

    // Stage 1: raw * gain
    logic signed [PROD_W-1:0]   w_prod;
    logic signed [PROD_W-1:0]   r_prod;

    // Stage 2: floor shift, bias, magnitude
    logic signed [PROD_W-1:0]   w_shift;
    logic signed [QUOT_W-1:0]   w_quot;
    logic signed [SCALED_W-1:0] w_scaled;
    logic        [SCALED_W-1:0] w_mag_full;
    logic signed [SCALED_W-1:0] r_scaled;
    logic        [MAG_W-1:0]    r_mag;

    // Stage 3: jump detection and counters
    logic signed [SCALED_W-1:0] r_scaled_out;
    logic        [MAG_W-1:0]    r_prev_mag;
    logic        [MAG_W-1:0]    w_diff;
    logic                       w_hit;
    logic        [CNT_W-1:0]    r_jump;
    logic        [CNT_W-1:0]    n_jump;
    logic        [CNT_W-1:0]    r_shake;
    logic        [CNT_W-1:0]    n_shake;

    // Signed 16 x unsigned 16 always fits 32 signed bits
    assign w_prod = PROD_W'(i_raw) * PROD_W'($signed({1'b0, i_gain}));

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld1) begin
            r_prod <= w_prod;
        end
    end

    assign w_shift    = r_prod >>> SCALE_SHIFT;
    assign w_quot     = w_shift[QUOT_W-1:0];
    assign w_scaled   = $signed({w_quot[QUOT_W-1], w_quot})
                      - $signed({{(SCALED_W-BIAS_W){i_bias[BIAS_W-1]}}, i_bias});
    assign w_mag_full = w_scaled[SCALED_W-1] ? (~w_scaled + 1'b1) : w_scaled;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld2) begin
            r_scaled <= w_scaled;
            r_mag    <= w_mag_full[MAG_W-1:0];
        end
    end

    // Magnitude change against the previous sample
    assign w_diff = (r_mag >= r_prev_mag) ? (r_mag - r_prev_mag) : (r_prev_mag - r_mag);
    assign w_hit  = i_ctl.check && ({{(LIM_W-MAG_W){1'b0}}, w_diff} > i_limit);

    always_comb begin
        n_jump  = r_jump;
        n_shake = r_shake;
        if (w_hit && (r_jump != '1)) begin
            n_jump = r_jump + 1'b1;
        end
        if (i_ctl.close) begin
            if (n_jump > JUMP_LIMIT) begin
                n_shake = r_shake + 1'b1;
            end
            n_jump = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld3) begin
            r_scaled_out <= r_scaled;
            r_prev_mag   <= r_mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jump  <= '0;
            r_shake <= '0;
        end else if (i_ctl.ld3) begin
            r_jump  <= n_jump;
            r_shake <= n_shake;
        end
    end

    assign o_scaled = r_scaled_out;
    assign o_shakes = r_shake;

    // Closing a window always leaves the jump count cleared
    a_jump_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.ld3 && i_ctl.close) |=> (r_jump == '0))
        else $error("jump count not cleared at window end");

endmodule

### rtl/ashk_seq.sv
`timescale 1ns / 1ps

module ashk_seq
    import ashk_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_adv,
    output t_seq_ctl o_ctl
);

    logic [POS_W-1:0]  r_pos;
    logic [PASS_W-1:0] r_pass;

    assign o_ctl.check = (r_pos >= POS_CHECK);
    assign o_ctl.close = (r_pos == POS_LAST) && (r_pass == PASS_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_pass <= '0;
        end else if (i_adv) begin
            if (r_pos == POS_LAST) begin
                r_pos <= '0;
                if (r_pass == PASS_LAST) begin
                    r_pass <= '0;
                end else begin
                    r_pass <= r_pass + 1'b1;
                end
            end else begin
                r_pos <= r_pos + 1'b1;
            end
        end
    end

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_LAST)
        else $error("ring position out of range");

    a_pass_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pass <= PASS_LAST)
        else $error("pass count out of range");

endmodule

### rtl/accel_shake_detector_core.sv
`timescale 1ns / 1ps

// Three-axis accelerometer shake detector.
//
// Input stream: one beat per raw XYZ sample on s_axis_tdata. Each axis is
// scaled as floor(raw * gain / 4096) - bias (milli-g) in its own lane, and the
// magnitude change against the previous sample is checked against the jump
// limit. Every 50 samples form a pass (positions 2..49 are checked); every
// third pass closes a window, and an axis with more than 10 jumps in the
// window bumps its 8-bit wrapping shake count.
// Output stream: one beat per input beat with the scaled samples and the
// shake counts on m_axis_tdata; m_axis_tlast marks the beat that closed a window.
// Configuration: write gains, biases and limits through i_cfg_we/idx/data
// while the stream is idle; writes take effect on the next edge.
// Pipeline: three register stages (multiply, scale, jump check); m_axis_tvalid
// rises when the sample is loaded into the jump-check (output) register.
// Throughput: one beat per cycle; a stalled output holds
// its beat while the earlier stages keep filling, and s_axis_tready drops only
// when all three stages are full and m_axis_tready is low.
// Reset: clears the pipeline, ring position, pass count, jump and shake
// counts and loads the default gains (246), biases (0), limits (40 / 50).

module accel_shake_detector_core
    import ashk_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // raw_x[15:0], raw_y[31:16], raw_z[47:32]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // scaled_x[20:0], scaled_y[41:21], scaled_z[62:42],
    // shakes_x[70:63], shakes_y[78:71], shakes_z[86:79], zero pad [87]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration registers
    logic [GAIN_W-1:0] r_gain [NUM_AXES];
    logic [BIAS_W-1:0] r_bias [NUM_AXES];
    logic [LIM_W-1:0]  r_lim_xy;
    logic [LIM_W-1:0]  r_lim_z;

    // Stage valids; stage 3 is the output register
    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic r_last;
    logic w_rdy1;
    logic w_rdy2;
    logic w_rdy3;
    logic w_ld1;
    logic w_ld2;
    logic w_ld3;

    t_seq_ctl  w_seq;
    t_lane_ctl w_lane_ctl;

    logic signed [SCALED_W-1:0] w_scaled [NUM_AXES];
    logic        [CNT_W-1:0]    w_shakes [NUM_AXES];

    // Register writes; idle-only by contract
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_gain[a] <= GAIN_RESET;
                r_bias[a] <= BIAS_RESET;
            end
            r_lim_xy <= LIMIT_XY_RESET;
            r_lim_z  <= LIMIT_Z_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_GAIN_X:   r_gain[0] <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_Y:   r_gain[1] <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_Z:   r_gain[2] <= i_cfg_data[GAIN_W-1:0];
                CFG_BIAS_X:   r_bias[0] <= i_cfg_data[BIAS_W-1:0];
                CFG_BIAS_Y:   r_bias[1] <= i_cfg_data[BIAS_W-1:0];
                CFG_BIAS_Z:   r_bias[2] <= i_cfg_data[BIAS_W-1:0];
                CFG_LIMIT_XY: r_lim_xy  <= i_cfg_data;
                CFG_LIMIT_Z:  r_lim_z   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Advance a stage when it is empty or its successor moves
    assign w_rdy3 = !r_v3 || m_axis_tready;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;

    assign w_ld1 = s_axis_tvalid && w_rdy1;
    assign w_ld2 = r_v1 && w_rdy2;
    assign w_ld3 = r_v2 && w_rdy3;

    assign s_axis_tready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= s_axis_tvalid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // Ring position and pass tracking, stepped as a sample enters stage 3
    ashk_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_ld3),
        .o_ctl   (w_seq)
    );

    assign w_lane_ctl.ld1   = w_ld1;
    assign w_lane_ctl.ld2   = w_ld2;
    assign w_lane_ctl.ld3   = w_ld3;
    assign w_lane_ctl.check = w_seq.check;
    assign w_lane_ctl.close = w_seq.close;

    // One lane per axis
    for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
        ashk_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_lane_ctl),
            .i_raw    ($signed(s_axis_tdata[g*RAW_W +: RAW_W])),
            .i_gain   (r_gain[g]),
            .i_bias   ($signed(r_bias[g])),
            .i_limit  ((g == AXIS_Z) ? r_lim_z : r_lim_xy),
            .o_scaled (w_scaled[g]),
            .o_shakes (w_shakes[g])
        );
    end

    // Merge: window flag rides with the output beat
    always_ff @(posedge i_clk) begin
        if (w_ld3) begin
            r_last <= w_seq.close;
        end
    end

    assign m_axis_tvalid = r_v3;
    assign m_axis_tlast  = r_last;
    assign m_axis_tdata  = {1'b0,
                            w_shakes[2], w_shakes[1], w_shakes[0],
                            w_scaled[2], w_scaled[1], w_scaled[0]};

    // Input stalls only when every stage holds a sample
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_v1 && r_v2 && r_v3))
        else $error("input stalled with an empty stage");

    // Shake counts move only on a window close
    a_shake_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_ld3 && w_seq.close) |=> $stable(m_axis_tdata[OUT_DATA_W-2:NUM_AXES*SCALED_W]))
        else $error("shake counts changed outside a window close");

endmodule

### bench/tb_accel_shake_detector_core.sv
`timescale 1ns / 1ps

module tb_accel_shake_detector_core;
    import ashk_pkg::*;

    localparam int STALL_LIMIT     = 4000;  // cycles without any beat before giving up
    localparam int HOLD_CYCLES     = 80;    // long output back-pressure stretch
    localparam int RANDOM_PHASES   = 7;
    localparam int BEATS_PER_PHASE = 200;
    localparam int TAIL_WINDOWS    = 1;     // gap-free shaking windows at the end
    localparam int DRAIN_CYCLES    = 8;     // pipeline is 3 deep, leave some margin

    // One output beat as the detector should produce it, axis 0 in the low bits
    typedef struct packed {
        logic [2:0][SCALED_W-1:0] scaled;
        logic [2:0][CNT_W-1:0]    shakes;
        logic                     closed;
    } t_reading;

    // Directed stimulus row: either a register write or one sample
    typedef struct packed {
        logic                     is_cfg;
        t_cfg_idx                 reg_idx;
        logic [CFG_DATA_W-1:0]    reg_val;
        logic [2:0][RAW_W-1:0]    raw;
        logic                     known;
        logic [2:0][SCALED_W-1:0] scaled;
    } t_row;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b1;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    accel_shake_detector_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Detector mirror: calibration registers and window state
    // ------------------------------------------------------------------
    logic [GAIN_W-1:0] gain_q [NUM_AXES];
    logic [BIAS_W-1:0] bias_q [NUM_AXES];
    logic [LIM_W-1:0]  limit_xy_q;
    logic [LIM_W-1:0]  limit_z_q;
    longint            prev_mg [NUM_AXES];
    int                ring_pos;
    int                pass_idx;
    int                jumps [NUM_AXES];
    logic [CNT_W-1:0]  shake_cnt [NUM_AXES];

    t_reading pending_q [$];   // expected beats, oldest first
    t_row     directed_q [$];

    int  errors         = 0;
    int  beats_sent     = 0;
    int  beats_checked  = 0;
    int  windows_closed = 0;
    int  settings_used  = 0;
    int  quiet_cycles   = 0;
    bit  gaps_on        = 1'b1;
    bit  tail_run       = 1'b0;
    bit  hold_req       = 1'b0;

    function automatic longint magnitude(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // floor(raw * gain / 4096) - bias, kept at the output width
    function automatic logic [SCALED_W-1:0] calibrate(logic [RAW_W-1:0] raw,
                                                      logic [GAIN_W-1:0] g,
                                                      logic [BIAS_W-1:0] b);
        longint prod;
        prod = longint'($signed(raw)) * longint'(g);
        return SCALED_W'((prod >>> SCALE_SHIFT) - longint'($signed(b)));
    endfunction

    function automatic void reset_detector();
        for (int a = 0; a < NUM_AXES; a++) begin
            gain_q[a]    = GAIN_RESET;
            bias_q[a]    = BIAS_RESET;
            prev_mg[a]   = 0;
            jumps[a]     = 0;
            shake_cnt[a] = '0;
        end
        limit_xy_q = LIMIT_XY_RESET;
        limit_z_q  = LIMIT_Z_RESET;
        ring_pos   = 0;
        pass_idx   = 0;
    endfunction

    function automatic void apply_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_GAIN_X, CFG_GAIN_Y, CFG_GAIN_Z: begin
                gain_q[int'(idx) - int'(CFG_GAIN_X)] = val[GAIN_W-1:0];
            end
            CFG_BIAS_X, CFG_BIAS_Y, CFG_BIAS_Z: begin
                bias_q[int'(idx) - int'(CFG_BIAS_X)] = val[BIAS_W-1:0];
            end
            CFG_LIMIT_XY: limit_xy_q = val[LIM_W-1:0];
            CFG_LIMIT_Z:  limit_z_q  = val[LIM_W-1:0];
            default: ;
        endcase
    endfunction

    // Advance the window state by one sample and return the beat it produces
    function automatic t_reading advance_detector(logic [2:0][RAW_W-1:0] raw);
        t_reading r;
        longint   cur;
        longint   lim;
        r.closed = 1'b0;
        for (int a = 0; a < NUM_AXES; a++) begin
            r.scaled[a] = calibrate(raw[a], gain_q[a], bias_q[a]);
            cur = longint'($signed(r.scaled[a]));
            lim = (a == AXIS_Z) ? longint'(limit_z_q) : longint'(limit_xy_q);
            // jump counts saturate rather than wrap
            if (ring_pos >= FIRST_CHECK_POS && jumps[a] < 255 &&
                magnitude(magnitude(cur) - magnitude(prev_mg[a])) > lim)
                jumps[a]++;
            prev_mg[a] = cur;
        end
        ring_pos++;
        if (ring_pos >= SAMPLES_PER_PASS) begin
            ring_pos = 0;
            pass_idx++;
            if (pass_idx >= PASSES_PER_WINDOW) begin
                pass_idx = 0;
                r.closed = 1'b1;
                for (int a = 0; a < NUM_AXES; a++) begin
                    if (jumps[a] > JUMP_COUNT_LIMIT)
                        shake_cnt[a] = shake_cnt[a] + 1'b1;   // wraps at 256
                    jumps[a] = 0;
                end
            end
        end
        for (int a = 0; a < NUM_AXES; a++)
            r.shakes[a] = shake_cnt[a];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Directed table helpers
    // ------------------------------------------------------------------
    function automatic void row_cfg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        t_row r;
        r         = '0;
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        directed_q.push_back(r);
    endfunction

    function automatic void row_beat(int x, int y, int z);
        t_row r;
        r        = '0;
        r.raw[0] = RAW_W'(x);
        r.raw[1] = RAW_W'(y);
        r.raw[2] = RAW_W'(z);
        directed_q.push_back(r);
    endfunction

    // Sample whose calibrated values are known by hand
    function automatic void row_known(int x, int y, int z, int ex, int ey, int ez);
        row_beat(x, y, z);
        directed_q[$].known     = 1'b1;
        directed_q[$].scaled[0] = SCALED_W'(ex);
        directed_q[$].scaled[1] = SCALED_W'(ey);
        directed_q[$].scaled[2] = SCALED_W'(ez);
    endfunction

    function automatic string axis_letter(int a);
        return (a == 0) ? "x" : (a == 1) ? "y" : "z";
    endfunction

    // ------------------------------------------------------------------
    // Stream driving
    // ------------------------------------------------------------------

    // Offer one sample, wait for the handshake, then queue its expected beat
    task automatic send_beat(logic [2:0][RAW_W-1:0] raw, logic known,
                             logic [2:0][SCALED_W-1:0] typed);
        t_reading r;
        i_cfg_we <= 1'b0;
        if (gaps_on && !tail_run && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        s_axis_tdata  <= raw;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        r = advance_detector(raw);
        if (known)
            r.scaled = typed;
        pending_q.push_back(r);
        beats_sent++;
        if (beats_sent % 40 == 0)
            gaps_on = $urandom_range(0, 1);
    endtask

    // Drop valid and wait until every expected beat has come out
    task automatic drain_stream();
        s_axis_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
    endtask

    // Register writes happen only with the stream drained; the next beat lowers we
    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        drain_stream();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        apply_reg(idx, val);
    endtask

    // Write all eight registers; style 0 = every maximum, 1 = every minimum
    task automatic program_setting(int style);
        logic [CFG_DATA_W-1:0] val;
        int pick;
        for (int r = 0; r < 8; r++) begin
            pick = (style == 0) ? 1 : (style == 1) ? 0 : $urandom_range(0, 9);
            if (r <= int'(CFG_GAIN_Z)) begin
                case (pick)
                    0:       val = '0;
                    1:       val = 20'h0FFFF;
                    2:       val = CFG_DATA_W'(GAIN_RESET);
                    default: val = CFG_DATA_W'($urandom_range(64, 1024));
                endcase
            end else if (r <= int'(CFG_BIAS_Z)) begin
                case (pick)
                    0:       val = 20'h08000;
                    1:       val = 20'h07FFF;
                    2:       val = CFG_DATA_W'(BIAS_RESET);
                    default: val = CFG_DATA_W'(16'($urandom_range(0, 4000) - 2000));
                endcase
            end else begin
                case (pick)
                    0:       val = '0;
                    1:       val = 20'hFFFFF;
                    2:       val = (r == int'(CFG_LIMIT_Z)) ? LIMIT_Z_RESET : LIMIT_XY_RESET;
                    default: val = CFG_DATA_W'($urandom_range(0, 400));
                endcase
            end
            write_reg(t_cfg_idx'(r), val);
        end
        settings_used++;
    endtask

    // Random samples in chunks of one pass: mostly shaped motion, some noise
    task automatic run_random(int count);
        logic [2:0][RAW_W-1:0] raw;
        int mode;
        int odds;
        int amp;
        int base [NUM_AXES];
        int step;
        for (int k = 0; k < count; k++) begin
            if (k % SAMPLES_PER_PASS == 0) begin
                mode = $urandom_range(0, 7);
                odds = $urandom_range(6, 24);
                amp  = $urandom_range(50, 20000);
                for (int a = 0; a < NUM_AXES; a++)
                    base[a] = int'($urandom_range(0, 16000)) - 8000;
            end
            for (int a = 0; a < NUM_AXES; a++) begin
                case (mode)
                    0: raw[a] = RAW_W'($urandom);                         // pure noise
                    1, 2: raw[a] = RAW_W'(base[a] + int'($urandom_range(0, 6)) - 3);
                    3, 4, 5: begin                                        // sparse jumps
                        step = int'($urandom_range(300, 12000));
                        if ($urandom_range(1, odds) == 1)
                            raw[a] = RAW_W'($urandom_range(0, 1) ? base[a] + step
                                                                 : base[a] - step);
                        else
                            raw[a] = RAW_W'(base[a] + int'($urandom_range(0, 6)) - 3);
                    end
                    default: raw[a] = RAW_W'(k[0] ? base[a] + amp : base[a]); // vibration
                endcase
            end
            send_beat(raw, 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------
    // Output side: random back-pressure plus one long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!tail_run && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end
        end
    end

    // Compare every output beat field by field against the oldest expectation
    always @(posedge i_clk) begin
        t_reading want;
        t_reading got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.scaled = m_axis_tdata[3*SCALED_W-1:0];
            got.shakes = m_axis_tdata[3*SCALED_W+3*CNT_W-1:3*SCALED_W];
            got.closed = m_axis_tlast;
            if (got.closed)
                windows_closed++;
            if (pending_q.size() == 0) begin
                $error("output beat arrived with no sample waiting for it");
                errors++;
            end else begin
                want = pending_q.pop_front();
                beats_checked++;
                for (int a = 0; a < NUM_AXES; a++) begin
                    if (got.scaled[a] !== want.scaled[a]) begin
                        $error("scaled_%s expected %0d actual %0d", axis_letter(a),
                               $signed(want.scaled[a]), $signed(got.scaled[a]));
                        errors++;
                    end
                    if (got.shakes[a] !== want.shakes[a]) begin
                        $error("shakes_%s expected %0d actual %0d", axis_letter(a),
                               want.shakes[a], got.shakes[a]);
                        errors++;
                    end
                end
                if (got.closed !== want.closed) begin
                    $error("window_end expected %0d actual %0d", want.closed, got.closed);
                    errors++;
                end
            end
        end
    end

    // Watchdog: count cycles in which no beat moves on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("accel_shake_detector_core verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        logic [2:0][RAW_W-1:0] raw;
        t_row row;

        reset_detector();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Default calibration: gain 246, no bias
        row_known(0, 0, 0, 0, 0, 0);
        row_known(-32768, 32767, -1, -1968, 1967, -1);
        row_known(32767, -32768, 1, 1967, -1968, 0);
        row_known(4096, -4096, 0, 246, -246, 0);
        row_known(-32768, -32768, -32768, -1968, -1968, -1968);
        row_beat('h5555, 'hAAAA, 'h7FFF);
        row_beat('hAAAA, 'h5555, 'h8000);
        // Full-scale gains with extreme biases: widest calibrated range
        row_cfg(CFG_GAIN_X, 20'h0FFFF);
        row_cfg(CFG_GAIN_Y, 20'h0FFFF);
        row_cfg(CFG_GAIN_Z, 20'h0FFFF);
        row_cfg(CFG_BIAS_X, 20'h07FFF);
        row_cfg(CFG_BIAS_Y, 20'h08000);
        row_cfg(CFG_LIMIT_XY, 20'h00000);
        row_cfg(CFG_LIMIT_Z, 20'hFFFFF);
        row_known(-32768, 32767, -32768, -557047, 557032, -524280);
        row_known(32767, -32768, 32767, 491497, -491512, 524264);
        row_known(0, 0, 0, -32767, 32768, 0);
        row_beat(1, -1, 'h00FF);
        // Zero gain leaves only the bias; swap the limits to the other extremes
        row_cfg(CFG_GAIN_X, 20'h00000);
        row_cfg(CFG_BIAS_X, 20'h08000);
        row_cfg(CFG_BIAS_Z, 20'h08000);
        row_cfg(CFG_LIMIT_Z, 20'h00000);
        row_cfg(CFG_LIMIT_XY, 20'hFFFFF);
        row_known(12345, -1, 32767, 32768, 32752, 557032);
        row_beat('h0F0F, 'hF0F0, -32768);
        row_beat(-12345, 'h3C3C, 2);

        foreach (directed_q[n]) begin
            row = directed_q[n];
            if (row.is_cfg)
                write_reg(row.reg_idx, row.reg_val);
            else
                send_beat(row.raw, row.known, row.scaled);
        end

        // Random phases, each with its own register setting
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            program_setting(ph);
            if (ph == 3)
                hold_req = 1'b1;   // fill the pipeline against a stalled output
            run_random(BEATS_PER_PHASE);
        end

        // Tail: steady shaking on every axis at default calibration, no gaps
        tail_run = 1'b1;
        for (int a = 0; a < NUM_AXES; a++) begin
            write_reg(t_cfg_idx'(int'(CFG_GAIN_X) + a), CFG_DATA_W'(GAIN_RESET));
            write_reg(t_cfg_idx'(int'(CFG_BIAS_X) + a), CFG_DATA_W'(BIAS_RESET));
        end
        write_reg(CFG_LIMIT_XY, LIMIT_XY_RESET);
        write_reg(CFG_LIMIT_Z, LIMIT_Z_RESET);
        settings_used++;
        for (int k = 0; k < TAIL_WINDOWS * PASSES_PER_WINDOW * SAMPLES_PER_PASS; k++) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                if (k[0])
                    raw[a] = $urandom_range(0, 1) ? RAW_W'($urandom_range(8000, 32767))
                                                  : RAW_W'(-int'($urandom_range(8000, 32767)));
                else
                    raw[a] = RAW_W'($urandom_range(0, 500));
            end
            send_beat(raw, 1'b0, '0);
        end

        drain_stream();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d of %0d sample beats across %0d register settings,",
                 beats_checked, beats_sent, settings_used);
        $display("with %0d detection windows closed, shake counts now %0d/%0d/%0d.",
                 windows_closed, shake_cnt[0], shake_cnt[1], shake_cnt[2]);
        if (errors == 0)
            $display("accel_shake_detector_core verification clean");
        else
            $display("accel_shake_detector_core verification failed");
        $finish;
    end

endmodule
